@@ sv/sptmr_pkg.sv @@
package sptmr_pkg;

    // default configuration
    localparam int DEF_MAX_PRESCALE_SELECT = 11;
    localparam int DEF_COUNTER_WIDTH       = 32;

    // bus width of the register interface
    localparam int DATA_W = 32;

    // request types
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // register map
    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_PERIOD = 3'd1;
    localparam logic [2:0] REG_COUNT  = 3'd2;
    localparam logic [2:0] REG_STATUS = 3'd3;
    localparam logic [2:0] REG_IRQEN  = 3'd4;

    // field positions
    localparam int CTRL_RUN_BIT     = 0;
    localparam int CTRL_PRESC_LSB   = 23;
    localparam int CTRL_PRESC_MSB   = 26;
    localparam int CTRL_MODE_LSB    = 16;
    localparam int CTRL_MODE_MSB    = 18;
    localparam int STATUS_OVF_BIT   = 8;
    localparam int IRQEN_OVF_BIT    = 16;

    // one result item
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_pending;
        logic              step_pulse;
        logic              step_release;
    } t_result;

endpackage

@@ sv/step_pulse_period_timer_unit.sv @@
// An accepted request's result is registered in the output buffer (output register, or skid
// register while the output is held). One request per cycle while o_in_stall is low; the state
// update is a single pass into the two-entry output buffer, which accepts while one result waits.
// Reset (synchronous, active low): timer stopped, period all ones, count, prescaler, flags
// and step phase cleared, output buffer empty.
module step_pulse_period_timer_unit
    import sptmr_pkg::*;
#(
    parameter int MAX_PRESCALE_SELECT = DEF_MAX_PRESCALE_SELECT,
    parameter int COUNTER_WIDTH       = DEF_COUNTER_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_req_type,
    input  logic [2:0]        i_reg_sel,
    input  logic [DATA_W-1:0] i_write_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DATA_W-1:0] o_read_data,
    output logic              o_irq_pending,
    output logic              o_step_pulse,
    output logic              o_step_release
);

    t_result w_result;
    t_result w_out;
    logic    w_accept;

    assign w_accept = i_in_valid & ~o_in_stall;

    // register file and counters
    sptmr_core #(
        .MAX_PRESCALE_SELECT (MAX_PRESCALE_SELECT),
        .COUNTER_WIDTH       (COUNTER_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_req_type   (i_req_type),
        .i_reg_sel    (i_reg_sel),
        .i_write_data (i_write_data),
        .o_result     (w_result)
    );

    // result buffer
    sptmr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (w_result),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (w_out)
    );

    assign o_read_data    = w_out.read_data;
    assign o_irq_pending  = w_out.irq_pending;
    assign o_step_pulse   = w_out.step_pulse;
    assign o_step_release = w_out.step_release;

endmodule

@@ sv/sptmr_core.sv @@
module sptmr_core
    import sptmr_pkg::*;
#(
    parameter int MAX_PRESCALE_SELECT = DEF_MAX_PRESCALE_SELECT,
    parameter int COUNTER_WIDTH       = DEF_COUNTER_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_req_type,
    input  logic [2:0]        i_reg_sel,
    input  logic [DATA_W-1:0] i_write_data,
    output t_result           o_result
);

    localparam int PW = (MAX_PRESCALE_SELECT > 0) ? MAX_PRESCALE_SELECT : 1;
    localparam logic [3:0] SEL_MAX = 4'(MAX_PRESCALE_SELECT);

    logic                     r_run,    n_run;
    logic [3:0]               r_presc,  n_presc;
    logic [2:0]               r_mode,   n_mode;
    logic [COUNTER_WIDTH-1:0] r_period, n_period;
    logic [COUNTER_WIDTH-1:0] r_count,  n_count;
    logic [PW-1:0]            r_pcount, n_pcount;
    logic                     r_ovf,    n_ovf;
    logic                     r_ien,    n_ien;
    logic                     r_phase,  n_phase;

    logic [3:0]  w_sel_sat;
    logic [PW:0] w_limit;
    logic [PW:0] w_pnext;
    logic        w_wen;

    // saturated prescale divider
    assign w_sel_sat = (r_presc > SEL_MAX) ? SEL_MAX : r_presc;
    assign w_limit   = (PW+1)'(1) << w_sel_sat;
    assign w_pnext   = {1'b0, r_pcount} + (PW+1)'(1);
    assign w_wen     = (i_write_data[IRQEN_OVF_BIT] == 1'b1);

    // next state and result for the accepted request
    always_comb begin
        n_run    = r_run;
        n_presc  = r_presc;
        n_mode   = r_mode;
        n_period = r_period;
        n_count  = r_count;
        n_pcount = r_pcount;
        n_ovf    = r_ovf;
        n_ien    = r_ien;
        n_phase  = r_phase;
        o_result = '0;
        if (i_req_type == REQ_TICK) begin
            if (r_run) begin
                if (w_pnext >= w_limit) begin
                    n_pcount = '0;
                    if (r_count >= r_period) begin
                        n_count = '0;
                        n_ovf   = 1'b1;
                        if (r_ien) begin
                            o_result.step_release = r_phase;
                            o_result.step_pulse   = ~r_phase;
                            n_phase               = ~r_phase;
                        end
                    end else begin
                        n_count = r_count + COUNTER_WIDTH'(1);
                    end
                end else begin
                    n_pcount = w_pnext[PW-1:0];
                end
            end
        end else if (i_req_type == REQ_WRITE) begin
            unique case (i_reg_sel)
                REG_CTRL: begin
                    n_run   = i_write_data[CTRL_RUN_BIT];
                    n_presc = i_write_data[CTRL_PRESC_MSB:CTRL_PRESC_LSB];
                    n_mode  = i_write_data[CTRL_MODE_MSB:CTRL_MODE_LSB];
                end
                REG_PERIOD: n_period = i_write_data[COUNTER_WIDTH-1:0];
                REG_COUNT:  n_count  = i_write_data[COUNTER_WIDTH-1:0];
                REG_STATUS: begin
                    if (i_write_data[STATUS_OVF_BIT]) n_ovf = 1'b0;
                end
                REG_IRQEN: begin
                    if (w_wen && !r_ien) n_phase = 1'b0;
                    n_ien = w_wen;
                end
                default: ;
            endcase
        end else if (i_req_type == REQ_READ) begin
            unique case (i_reg_sel)
                REG_CTRL: begin
                    o_result.read_data[CTRL_RUN_BIT]                  = r_run;
                    o_result.read_data[CTRL_PRESC_MSB:CTRL_PRESC_LSB] = r_presc;
                    o_result.read_data[CTRL_MODE_MSB:CTRL_MODE_LSB]   = r_mode;
                end
                REG_PERIOD: o_result.read_data = DATA_W'(r_period);
                REG_COUNT:  o_result.read_data = DATA_W'(r_count);
                REG_STATUS: o_result.read_data[STATUS_OVF_BIT] = r_ovf;
                REG_IRQEN:  o_result.read_data[IRQEN_OVF_BIT]  = r_ien;
                default: ;
            endcase
        end
        o_result.irq_pending = n_ovf & n_ien;
    end

    // timer state, updated only on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_presc  <= '0;
            r_mode   <= '0;
            r_period <= '1;
            r_count  <= '0;
            r_pcount <= '0;
            r_ovf    <= 1'b0;
            r_ien    <= 1'b0;
            r_phase  <= 1'b0;
        end else if (i_accept) begin
            r_run    <= n_run;
            r_presc  <= n_presc;
            r_mode   <= n_mode;
            r_period <= n_period;
            r_count  <= n_count;
            r_pcount <= n_pcount;
            r_ovf    <= n_ovf;
            r_ien    <= n_ien;
            r_phase  <= n_phase;
        end
    end

endmodule

@@ sv/sptmr_out_buf.sv @@
module sptmr_out_buf
    import sptmr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    logic    r_out_valid,  n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out,        n_out;
    t_result r_skid,       n_skid;
    logic    w_take;
    logic    w_put;

    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign w_take  = r_out_valid & ~i_stall;
    assign w_put   = i_valid & ~r_skid_valid;

    // two-entry buffer: output register plus skid register
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (w_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (w_put) begin
            if (!r_out_valid || w_take) begin
                n_out       = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (w_take) begin
            n_out_valid = 1'b0;
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

@@ tb/sv/sptmr_result_checker.sv @@
module sptmr_result_checker
    import sptmr_pkg::*;
#(
    parameter int MAX_PRESCALE_SELECT = DEF_MAX_PRESCALE_SELECT,
    parameter int COUNTER_WIDTH       = DEF_COUNTER_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_req_type,
    input  logic [2:0]        i_reg_sel,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [DATA_W-1:0] i_read_data,
    input  logic              i_irq_pending,
    input  logic              i_step_pulse,
    input  logic              i_step_release,
    output int                o_fail_count,
    output int                o_pending
);

    // timer state as the predictor sees it
    logic                     tmr_run;
    logic [3:0]               tmr_presc_sel;
    logic [2:0]               tmr_mode;
    logic [COUNTER_WIDTH-1:0] tmr_period;
    logic [COUNTER_WIDTH-1:0] tmr_count;
    int                       tmr_presc_cnt;
    logic                     tmr_ovf;
    logic                     tmr_ovf_ie;
    logic                     tmr_step_hi;

    t_result expected_results[$];
    t_result exp_res;
    t_result got_res;
    int      fail_total = 0;
    int      expected_count = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = expected_count;

    // apply one request to the predicted timer and form its result
    task automatic apply_request(input logic [1:0] req, input logic [2:0] sel,
                                 input logic [DATA_W-1:0] data, output t_result res);
        int eff_sel;
        int divider;
        res = '0;
        case (req)
            REQ_TICK: begin
                if (tmr_run) begin
                    eff_sel = (int'(tmr_presc_sel) > MAX_PRESCALE_SELECT) ?
                              MAX_PRESCALE_SELECT : int'(tmr_presc_sel);
                    divider = 1 << eff_sel;
                    // a divider shrunk below the prescaler count fires at once
                    if (tmr_presc_cnt + 1 >= divider) begin
                        tmr_presc_cnt = 0;
                        if (tmr_count >= tmr_period) begin
                            tmr_count = '0;
                            tmr_ovf   = 1'b1;
                            if (tmr_ovf_ie) begin
                                res.step_pulse   = !tmr_step_hi;
                                res.step_release = tmr_step_hi;
                                tmr_step_hi      = !tmr_step_hi;
                            end
                        end else begin
                            tmr_count = tmr_count + 1'b1;
                        end
                    end else begin
                        tmr_presc_cnt = tmr_presc_cnt + 1;
                    end
                end
            end
            REQ_WRITE: begin
                case (sel)
                    REG_CTRL: begin
                        tmr_run       = data[CTRL_RUN_BIT];
                        tmr_presc_sel = data[CTRL_PRESC_MSB:CTRL_PRESC_LSB];
                        tmr_mode      = data[CTRL_MODE_MSB:CTRL_MODE_LSB];
                    end
                    REG_PERIOD: tmr_period = data[COUNTER_WIDTH-1:0];
                    REG_COUNT:  tmr_count = data[COUNTER_WIDTH-1:0];
                    REG_STATUS: begin
                        if (data[STATUS_OVF_BIT]) tmr_ovf = 1'b0;
                    end
                    REG_IRQEN: begin
                        // phase restarts only when the enable rises
                        if (data[IRQEN_OVF_BIT] && !tmr_ovf_ie) tmr_step_hi = 1'b0;
                        tmr_ovf_ie = data[IRQEN_OVF_BIT];
                    end
                    default: ;
                endcase
            end
            REQ_READ: begin
                case (sel)
                    REG_CTRL: begin
                        res.read_data[CTRL_RUN_BIT]                   = tmr_run;
                        res.read_data[CTRL_PRESC_MSB:CTRL_PRESC_LSB] = tmr_presc_sel;
                        res.read_data[CTRL_MODE_MSB:CTRL_MODE_LSB]   = tmr_mode;
                    end
                    REG_PERIOD: res.read_data = DATA_W'(tmr_period);
                    REG_COUNT:  res.read_data = DATA_W'(tmr_count);
                    REG_STATUS: res.read_data[STATUS_OVF_BIT] = tmr_ovf;
                    REG_IRQEN:  res.read_data[IRQEN_OVF_BIT] = tmr_ovf_ie;
                    default: ;
                endcase
            end
            default: ;
        endcase
        res.irq_pending = tmr_ovf & tmr_ovf_ie;
    endtask

    // watch both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tmr_run        = 1'b0;
            tmr_presc_sel  = '0;
            tmr_mode       = '0;
            tmr_period     = '1;
            tmr_count      = '0;
            tmr_presc_cnt  = 0;
            tmr_ovf        = 1'b0;
            tmr_ovf_ie     = 1'b0;
            tmr_step_hi    = 1'b0;
            expected_results.delete();
            expected_count = 0;
        end else begin
            // compare a delivered result with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                got_res.read_data    = i_read_data;
                got_res.irq_pending  = i_irq_pending;
                got_res.step_pulse   = i_step_pulse;
                got_res.step_release = i_step_release;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result read_data %h irq %b pulse %b release %b",
                             $time, i_read_data, i_irq_pending, i_step_pulse, i_step_release);
                    fail_total = fail_total + 1;
                end else begin
                    exp_res = expected_results.pop_front();
                    expected_count = expected_count - 1;
                    if (got_res.read_data !== exp_res.read_data) begin
                        $display("%0t: read_data expected %h got %h",
                                 $time, exp_res.read_data, got_res.read_data);
                        fail_total = fail_total + 1;
                    end
                    if (got_res.irq_pending !== exp_res.irq_pending) begin
                        $display("%0t: irq_pending expected %b got %b",
                                 $time, exp_res.irq_pending, got_res.irq_pending);
                        fail_total = fail_total + 1;
                    end
                    if (got_res.step_pulse !== exp_res.step_pulse) begin
                        $display("%0t: step_pulse expected %b got %b",
                                 $time, exp_res.step_pulse, got_res.step_pulse);
                        fail_total = fail_total + 1;
                    end
                    if (got_res.step_release !== exp_res.step_release) begin
                        $display("%0t: step_release expected %b got %b",
                                 $time, exp_res.step_release, got_res.step_release);
                        fail_total = fail_total + 1;
                    end
                end
            end
            // predict the result of an accepted request
            if (i_in_valid && !i_in_stall) begin
                apply_request(i_req_type, i_reg_sel, i_write_data, exp_res);
                expected_results.push_back(exp_res);
                expected_count = expected_count + 1;
            end
        end
    end

endmodule

@@ tb/sv/tb_step_pulse_period_timer_unit.sv @@
module tb_step_pulse_period_timer_unit;
    import sptmr_pkg::*;

    localparam logic [1:0] REQ_NONE           = 2'd3;
    localparam logic [2:0] REG_UNMAPPED_FIRST = 3'd5;
    localparam logic [2:0] REG_UNMAPPED_LAST  = 3'd7;
    localparam int         REQUEST_TARGET     = 1850;
    localparam int         CYCLE_LIMIT        = 200000;
    localparam int         DRAIN_LIMIT        = 1000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        req_type = REQ_TICK;
    logic [2:0]        reg_sel = REG_CTRL;
    logic [DATA_W-1:0] write_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DATA_W-1:0] read_data;
    logic              irq_pending;
    logic              step_pulse;
    logic              step_release;

    int fail_count;
    int pending;
    int idle_rate = 0;
    int stall_left = 0;
    int requests_sent = 0;
    int cycle_count = 0;
    int drain_cycles;
    int burst_len;
    int pick;

    always #5 clk = ~clk;

    step_pulse_period_timer_unit u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_req_type     (req_type),
        .i_reg_sel      (reg_sel),
        .i_write_data   (write_data),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_read_data    (read_data),
        .o_irq_pending  (irq_pending),
        .o_step_pulse   (step_pulse),
        .o_step_release (step_release)
    );

    sptmr_result_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_req_type     (req_type),
        .i_reg_sel      (reg_sel),
        .i_write_data   (write_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_read_data    (read_data),
        .i_irq_pending  (irq_pending),
        .i_step_pulse   (step_pulse),
        .i_step_release (step_release),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("step_pulse_period_timer_unit regression: fail");
            $finish;
        end
    end

    // result side back-pressure in short bursts
    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end else begin
            out_stall  <= 1'b0;
        end
    end

    // present one request, with an optional idle gap, and wait for its acceptance
    task automatic send_request(input logic [1:0] req, input logic [2:0] sel,
                                input logic [DATA_W-1:0] data);
        if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        reg_sel    <= sel;
        write_data <= data;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        requests_sent = requests_sent + 1;
        @(negedge clk);
    endtask

    // control word, mostly with small prescale selects
    function automatic logic [DATA_W-1:0] ctrl_word(input bit run);
        logic [DATA_W-1:0] w;
        w = $urandom;
        w[CTRL_RUN_BIT] = run;
        w[CTRL_PRESC_MSB:CTRL_PRESC_LSB] = ($urandom_range(0, 4) != 0) ?
            4'($urandom_range(0, 2)) : 4'($urandom_range(0, 15));
        return w;
    endfunction

    // period, mostly short so that wraps come often
    function automatic logic [DATA_W-1:0] period_word();
        if ($urandom_range(0, 3) == 0) return DATA_W'($urandom);
        return DATA_W'($urandom_range(0, 6));
    endfunction

    initial begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values, unmapped register, unknown request, tick while stopped
        send_request(REQ_READ, REG_CTRL, $urandom);
        send_request(REQ_READ, REG_PERIOD, $urandom);
        send_request(REQ_READ, REG_COUNT, $urandom);
        send_request(REQ_READ, REG_STATUS, $urandom);
        send_request(REQ_READ, REG_IRQEN, $urandom);
        send_request(REQ_READ, REG_UNMAPPED_LAST, $urandom);
        send_request(REQ_NONE, REG_CTRL, '1);
        send_request(REQ_TICK, REG_CTRL, '0);
        send_request(REQ_WRITE, REG_UNMAPPED_FIRST, '1);
        // run with a select above the saturation point
        send_request(REQ_WRITE, REG_CTRL, '1);
        send_request(REQ_READ, REG_CTRL, '0);
        repeat (2) send_request(REQ_TICK, REG_CTRL, $urandom);
        // count above period, enable rising, then divider shrunk mid-count
        send_request(REQ_WRITE, REG_PERIOD, DATA_W'(2));
        send_request(REQ_WRITE, REG_COUNT, '1);
        send_request(REQ_WRITE, REG_IRQEN, DATA_W'(1) << IRQEN_OVF_BIT);
        send_request(REQ_WRITE, REG_CTRL,
                     (DATA_W'(1) << CTRL_PRESC_LSB) | (DATA_W'(1) << CTRL_RUN_BIT));
        repeat (4) send_request(REQ_TICK, REG_CTRL, $urandom);
        send_request(REQ_READ, REG_STATUS, $urandom);
        send_request(REQ_WRITE, REG_STATUS, DATA_W'(1) << STATUS_OVF_BIT);
        // wraps with the interrupt disabled and a zero period
        send_request(REQ_WRITE, REG_IRQEN, '0);
        send_request(REQ_WRITE, REG_PERIOD, '0);
        repeat (2) send_request(REQ_TICK, REG_CTRL, $urandom);

        // random scenarios: set up a running timer, then mostly ticks
        while (requests_sent < REQUEST_TARGET) begin
            if (requests_sent > REQUEST_TARGET * 9 / 10) begin
                idle_rate = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: idle_rate = 0;
                    1: idle_rate = 3;
                    default: idle_rate = 6;
                endcase
            end
            if ($urandom_range(0, 9) != 0) begin
                send_request(REQ_WRITE, REG_PERIOD, period_word());
                case ($urandom_range(0, 2))
                    0: send_request(REQ_WRITE, REG_COUNT, '0);
                    1: send_request(REQ_WRITE, REG_COUNT, DATA_W'($urandom_range(0, 8)));
                    default: send_request(REQ_WRITE, REG_COUNT, $urandom);
                endcase
                send_request(REQ_WRITE, REG_IRQEN, $urandom);
                send_request(REQ_WRITE, REG_CTRL, ctrl_word(1'b1));
            end
            burst_len = $urandom_range(10, 60);
            repeat (burst_len) begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    send_request(REQ_TICK, 3'($urandom), $urandom);
                else if (pick < 77)
                    send_request(REQ_READ, 3'($urandom), $urandom);
                else if (pick < 82)
                    send_request(REQ_WRITE, REG_STATUS, $urandom);
                else if (pick < 87)
                    send_request(REQ_WRITE, REG_IRQEN, $urandom);
                else if (pick < 91)
                    send_request(REQ_WRITE, REG_CTRL, ctrl_word($urandom_range(0, 7) != 0));
                else if (pick < 94)
                    send_request(REQ_WRITE, REG_PERIOD, period_word());
                else if (pick < 96)
                    send_request(REQ_WRITE, REG_COUNT, $urandom);
                else if (pick < 98)
                    send_request(REQ_WRITE,
                                 3'($urandom_range(REG_UNMAPPED_FIRST, REG_UNMAPPED_LAST)),
                                 $urandom);
                else
                    send_request(REQ_NONE, 3'($urandom), $urandom);
            end
        end
        in_valid <= 1'b0;
        idle_rate = 0;

        // drain outstanding results, then a few more cycles
        drain_cycles = 0;
        while (pending != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(negedge clk);
            drain_cycles = drain_cycles + 1;
        end
        repeat (4) @(negedge clk);
        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);

        if (fail_count == 0 && pending == 0)
            $display("step_pulse_period_timer_unit regression: pass");
        else
            $display("step_pulse_period_timer_unit regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
sv/sptmr_pkg.sv
sv/sptmr_core.sv
sv/sptmr_out_buf.sv
sv/step_pulse_period_timer_unit.sv
tb/sv/sptmr_result_checker.sv
tb/sv/tb_step_pulse_period_timer_unit.sv
